@@ hw/rtl/assert_macros.svh @@
// assertion macros used by comb_sort_engine
// needs clk_i in the scope of each use, and rst_ni as well for CSE_ASSERT
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked on every rising clock edge, reset included
`define CSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/cse_pkg.sv @@
// types, constants and gap shrink function of the comb sort engine
// no dependencies
package cse_pkg;

  localparam int MaxElements = 64;
  localparam int AddrW       = $clog2(MaxElements);
  localparam int CntW        = $clog2(MaxElements + 1);
  localparam int SumW        = CntW + 1;
  localparam int ValueW      = 32;

  // floor(g * 1000 / 1247) as (g * GapMul) >> GapShift, exact for g < 128
  localparam int GapShift    = 16;
  localparam int GapMulW     = 16;
  localparam logic [GapMulW-1:0] GapMul = 16'd52555;
  localparam int GapProdW    = GapMulW + CntW;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     descending;
    logic                     last;
  } cse_in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] sorted_value;
    logic                     end_of_set;
    logic                     overflow;
  } cse_out_t;

  typedef enum logic [7:0] {
    S_LOAD    = 8'b0000_0001,
    S_PASS    = 8'b0000_0010,
    S_RD      = 8'b0000_0100,
    S_CMP     = 8'b0000_1000,
    S_WR2     = 8'b0001_0000,
    S_CHECK   = 8'b0010_0000,
    S_EMIT_RD = 8'b0100_0000,
    S_EMIT_LD = 8'b1000_0000
  } cse_state_e;

  function automatic logic [CntW-1:0] shrink_gap(input logic [CntW-1:0] gap);
    logic [GapProdW-1:0] prod;
    logic [CntW-1:0]     res;
    prod = GapProdW'(gap) * GapProdW'(GapMul);
    res  = CntW'(prod >> GapShift);
    if (res == '0) begin
      res = CntW'(1);
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/comb_sort_engine.sv @@
// comb sort engine: loads a set at one item per cycle, then sorts and emits it
// load: the last item starts the sort and stalls the input
// sort: per pass a set-up state and a check state, a read and a compare state per pair, an extra write state per swap,
//   bound by the single two-read one-write element ram
// emit: each result is read, then loaded into a registered output once it is free; input reopens after the last
// reset (async, active low) empties the set, ascending direction, no result pending
module comb_sort_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cse_pkg::cse_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cse_pkg::cse_out_t out_data_o
);
  import cse_pkg::*;

  cse_state_e       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  gap_q, gap_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] k_q, k_d;
  logic             dir_q, dir_d;
  logic             dropped_q, dropped_d;
  logic             swap_q, swap_d;
  logic             out_valid_q, out_valid_d;
  cse_out_t         out_q, out_d;

  logic              we;
  logic [AddrW-1:0]  waddr, raddr_a, raddr_b;
  logic [ValueW-1:0] wdata, rdata_a, rdata_b;

  logic             in_xfer, can_load, out_of_order, is_last_k;
  logic [SumW-1:0]  j_sum, jn_sum;
  logic [CntW-1:0]  gap_new;

  logic             pair_busy, pair_ok, emit_last, set_closed;

  cse_ram #(
    .Width (ValueW),
    .Depth (MaxElements)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign in_stall_o  = (state_q != S_LOAD);
  assign in_xfer     = in_valid_i && (state_q == S_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign can_load    = !out_valid_q || !out_stall_i;

  assign j_sum   = SumW'(idx_q) + SumW'(gap_q);
  assign jn_sum  = j_sum + SumW'(1);
  assign gap_new = shrink_gap(gap_q);

  assign out_of_order = dir_q ? ($signed(rdata_a) < $signed(rdata_b))
                              : ($signed(rdata_a) > $signed(rdata_b));
  assign is_last_k    = (SumW'(k_q) + SumW'(1)) == SumW'(count_q);

  assign raddr_a = ((state_q == S_EMIT_RD) || (state_q == S_EMIT_LD)) ? k_q : idx_q;
  assign raddr_b = j_sum[AddrW-1:0];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    gap_d       = gap_q;
    idx_d       = idx_q;
    k_d         = k_q;
    dir_d       = dir_q;
    dropped_d   = dropped_q;
    swap_d      = swap_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = rdata_b;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_LOAD: begin
        if (in_xfer) begin
          if (count_q == '0) begin
            dir_d = in_data_i.descending;
          end
          if (count_q < CntW'(MaxElements)) begin
            we      = 1'b1;
            waddr   = count_q[AddrW-1:0];
            wdata   = in_data_i.value;
            count_d = count_q + CntW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (in_data_i.last) begin
            gap_d   = count_d;
            state_d = S_PASS;
          end
        end
      end
      S_PASS: begin
        gap_d  = gap_new;
        idx_d  = '0;
        swap_d = 1'b0;
        state_d = (SumW'(gap_new) < SumW'(count_q)) ? S_RD : S_CHECK;
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (out_of_order) begin
          we      = 1'b1;
          waddr   = idx_q;
          wdata   = rdata_b;
          swap_d  = 1'b1;
          state_d = S_WR2;
        end else if (jn_sum < SumW'(count_q)) begin
          idx_d   = idx_q + AddrW'(1);
          state_d = S_RD;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_WR2: begin
        we    = 1'b1;
        waddr = j_sum[AddrW-1:0];
        wdata = rdata_a;
        if (jn_sum < SumW'(count_q)) begin
          idx_d   = idx_q + AddrW'(1);
          state_d = S_RD;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((gap_q > CntW'(1)) || swap_q) begin
          state_d = S_PASS;
        end else begin
          k_d     = '0;
          state_d = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (can_load) begin
          out_valid_d        = 1'b1;
          out_d.sorted_value = rdata_a;
          out_d.end_of_set   = is_last_k;
          out_d.overflow     = dropped_q;
          if (is_last_k) begin
            count_d   = '0;
            dropped_d = 1'b0;
            state_d   = S_LOAD;
          end else begin
            k_d     = k_q + AddrW'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      gap_q       <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      dir_q       <= 1'b0;
      dropped_q   <= 1'b0;
      swap_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      gap_q       <= gap_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      dir_q       <= dir_d;
      dropped_q   <= dropped_d;
      swap_q      <= swap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign pair_busy  = (state_q == S_RD) || (state_q == S_CMP) || (state_q == S_WR2);
  assign pair_ok    = (gap_q != '0) && (j_sum < SumW'(count_q));
  assign emit_last  = (state_q == S_EMIT_LD) && can_load && is_last_k;
  assign set_closed = (state_q == S_LOAD) && (count_q == '0) && out_valid_q
                      && out_q.end_of_set;

`include "assert_macros.svh"

  `CSE_ASSERT(a_count_bound, count_q <= CntW'(MaxElements), "element count above buffer size")
  `CSE_ASSERT(a_cmp_in_range, pair_busy |-> pair_ok, "compare pair outside the set")
  `CSE_ASSERT(a_sort_nonempty, (state_q == S_PASS) |-> (count_q != '0), "sort on an empty set")
  `CSE_ASSERT(a_set_done, emit_last |=> set_closed, "final transfer did not close the set")

endmodule

@@ hw/rtl/cse_ram.sv @@
// generic ram, one write port and two registered read ports
// no dependencies
module cse_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
